@@ hw/rtl/cclim_pkg.sv @@
// ----------------------------------------------------------------------------
// cclim_pkg
// Types and constants shared by the chassis current power limiter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cclim_pkg;

	localparam int unsigned NUM_LANES   = 4;
	localparam int unsigned DIV_STEPS   = 16;
	localparam int unsigned IDLE_POWER  = 200;
	localparam int unsigned IDLE_SAT    = 255;
	localparam int unsigned PCT         = 100;
	localparam int unsigned SLEW_BIG    = 2000;
	localparam int unsigned SLEW_MID    = 1000;
	localparam int unsigned SLEW_DIV_HI = 100;
	localparam int unsigned SLEW_DIV_LO = 50;
	localparam int unsigned SLEW_MUL_HI = 99;
	localparam int unsigned SLEW_MUL_LO = 49;

	typedef enum logic [1:0] {
		MODE_BUFFER = 2'd0,
		MODE_CAP    = 2'd1,
		MODE_NONE   = 2'd2,
		MODE_UNLIM  = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_BUFFER_MARGIN    = 3'd0,
		REG_POWER_BASE_DW    = 3'd1,
		REG_LIMIT_BASE       = 3'd2,
		REG_LIMIT_PER_BUFFER = 3'd3,
		REG_CURRENT_CAP      = 3'd4,
		REG_CAP_MIN_MV       = 3'd5,
		REG_UNLIMIT_TICKS    = 3'd6,
		REG_SLEW_TRIGGER     = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MUL,
		S_LOAD,
		S_DIV,
		S_POST,
		S_SLEW,
		S_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic sel_ext;
		logic step;
	} lane_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/cclim_lane.sv @@
// ----------------------------------------------------------------------------
// cclim_lane
// One current lane: magnitude times limit product and a 16-step restoring
// divider giving a signed quotient truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cclim_lane (
	input  wire logic                clk,
	input  wire cclim_pkg::lane_ctrl_t ctrl,
	input  wire logic signed [15:0]  cur,
	input  wire logic        [17:0]  lim,
	input  wire logic        [21:0]  ext_mag,
	input  wire logic                ext_neg,
	input  wire logic        [17:0]  divisor,
	output logic signed      [15:0]  quot
);

	logic [15:0] cur_mag;
	logic [32:0] prod_s1;
	logic [32:0] dvd;
	logic [17:0] rem_q;
	logic [15:0] low_q;
	logic [15:0] quot_q;
	logic        neg_q;
	logic [18:0] trial;
	logic        fits;

	assign cur_mag = cur[15] ? 16'(-cur) : 16'(cur);
	assign dvd     = ctrl.sel_ext ? {11'd0, ext_mag} : prod_s1;
	assign trial   = {rem_q, low_q[15]};
	assign fits    = trial >= {1'b0, divisor};

	always_ff @(posedge clk) begin
		prod_s1 <= 33'(cur_mag) * 33'(lim);
		if (ctrl.load) begin
			rem_q  <= {1'b0, dvd[32:16]};
			low_q  <= dvd[15:0];
			quot_q <= '0;
			neg_q  <= ctrl.sel_ext ? ext_neg : cur[15];
		end else if (ctrl.step) begin
			rem_q  <= fits ? 18'(trial - {1'b0, divisor}) : trial[17:0];
			low_q  <= {low_q[14:0], 1'b0};
			quot_q <= {quot_q[14:0], fits};
		end
	end

	assign quot = neg_q ? signed'(16'(-quot_q)) : signed'(quot_q);

endmodule

`default_nettype wire

@@ hw/rtl/chassis_current_power_limiter.sv @@
// ----------------------------------------------------------------------------
// chassis_current_power_limiter
// Limits four motor current commands by buffer energy, capacitor state and
// slew, with an idle-latched unlimited mode.
// ----------------------------------------------------------------------------
// One word is taken at a time. In unlimited mode the result skips the
// dividers; otherwise the four lanes each run a 16-step restoring divider
// up to twice, once for the buffer or cap scaling when it applies and once
// more for the slew step (division by 100 or 50) when that applies.
// in_ready rises again once the result is in the output register; a result
// left waiting holds the block in its last state until out_ready takes it.
`default_nettype none

module chassis_current_power_limiter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_wen,
	input  wire logic        [2:0]  cfg_index,
	input  wire logic        [17:0] cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [15:0] front_left,
	input  wire logic signed [15:0] front_right,
	input  wire logic signed [15:0] back_left,
	input  wire logic signed [15:0] back_right,
	input  wire logic        [15:0] power_dw,
	input  wire logic        [9:0]  energy_buffer,
	input  wire logic               cap_releasing,
	input  wire logic        [15:0] cap_voltage_mv,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed      [15:0] out_front_left,
	output logic signed      [15:0] out_front_right,
	output logic signed      [15:0] out_back_left,
	output logic signed      [15:0] out_back_right,
	output logic             [1:0]  limit_mode
);

	logic [7:0]  buffer_margin_q;
	logic [11:0] power_base_dw_q;
	logic [15:0] limit_base_q;
	logic [9:0]  limit_per_buffer_q;
	logic [17:0] current_cap_q;
	logic [15:0] cap_min_mv_q;
	logic [7:0]  unlimit_ticks_q;
	logic [17:0] slew_trigger_q;

	cclim_pkg::state_t state_q, state_d;
	cclim_pkg::mode_t  mode_q;
	cclim_pkg::lane_ctrl_t lane_ctrl;

	logic signed [15:0] c_q    [cclim_pkg::NUM_LANES];
	logic signed [15:0] prev_q [cclim_pkg::NUM_LANES];
	logic signed [15:0] lane_q [cclim_pkg::NUM_LANES];
	logic        [21:0] ext_mag[cclim_pkg::NUM_LANES];
	logic               ext_neg[cclim_pkg::NUM_LANES];

	logic [15:0] power_q;
	logic [9:0]  buffer_q;
	logic        releasing_q;
	logic [15:0] volt_q;
	logic [7:0]  idle_q;
	logic        unl_q;
	logic [17:0] sum_q;
	logic [17:0] lim_q;
	logic [17:0] divisor_q;
	logic        scale_q;
	logic        phase_q;
	logic [3:0]  step_q;

	logic        in_fire, done_fire;
	logic [17:0] sum;
	logic [15:0] c_mag [cclim_pkg::NUM_LANES];
	logic [7:0]  idle_inc;
	logic [7:0]  idle_next;
	logic        unl_next;
	logic [16:0] excess;
	logic [17:0] buf_pct;
	logic [17:0] margin_sum;
	logic [20:0] lim_raw;
	logic        slew_on;
	logic        slew_big, slew_mid;
	logic signed [15:0] p_v [cclim_pkg::NUM_LANES];
	logic signed [16:0] dfl;
	logic        [16:0] dfl_abs;

	assign in_fire   = in_valid && in_ready;
	assign done_fire = (state_q == cclim_pkg::S_DONE) && (!out_valid || out_ready);
	assign in_ready  = state_q == cclim_pkg::S_IDLE;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_margin_q    <= 8'd20;
			power_base_dw_q    <= 12'd700;
			limit_base_q       <= 16'd2500;
			limit_per_buffer_q <= 10'd192;
			current_cap_q      <= 18'd14500;
			cap_min_mv_q       <= 16'd12000;
			unlimit_ticks_q    <= 8'd200;
			slew_trigger_q     <= 18'd11000;
		end else if (cfg_wen) begin
			case (cclim_pkg::reg_idx_t'(cfg_index))
				cclim_pkg::REG_BUFFER_MARGIN:    buffer_margin_q    <= cfg_data[7:0];
				cclim_pkg::REG_POWER_BASE_DW:    power_base_dw_q    <= cfg_data[11:0];
				cclim_pkg::REG_LIMIT_BASE:       limit_base_q       <= cfg_data[15:0];
				cclim_pkg::REG_LIMIT_PER_BUFFER: limit_per_buffer_q <= cfg_data[9:0];
				cclim_pkg::REG_CURRENT_CAP:      current_cap_q      <= cfg_data;
				cclim_pkg::REG_CAP_MIN_MV:       cap_min_mv_q       <= cfg_data[15:0];
				cclim_pkg::REG_UNLIMIT_TICKS:    unlimit_ticks_q    <= cfg_data[7:0];
				cclim_pkg::REG_SLEW_TRIGGER:     slew_trigger_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	// tick evaluation
	always_comb begin
		sum = '0;
		for (int i = 0; i < cclim_pkg::NUM_LANES; i++) begin
			c_mag[i] = c_q[i][15] ? 16'(-c_q[i]) : 16'(c_q[i]);
			sum      = sum + 18'(c_mag[i]);
		end
		idle_inc = (power_q < 16'(cclim_pkg::IDLE_POWER) && idle_q != 8'(cclim_pkg::IDLE_SAT))
			? 8'(idle_q + 8'd1) : idle_q;
		if (buffer_q != '0) begin
			idle_next = '0;
			unl_next  = 1'b0;
		end else if (idle_inc > unlimit_ticks_q) begin
			idle_next = '0;
			unl_next  = 1'b1;
		end else begin
			idle_next = idle_inc;
			unl_next  = unl_q;
		end
		excess     = (power_q > 16'(power_base_dw_q)) ? 17'(power_q - 16'(power_base_dw_q)) : '0;
		buf_pct    = 18'(buffer_q) * 18'(cclim_pkg::PCT);
		margin_sum = 18'(18'(buffer_margin_q) * 18'(cclim_pkg::PCT)) + 18'(excess);
		lim_raw    = 21'(limit_base_q) + 21'(21'(limit_per_buffer_q) * 21'(buffer_q));
	end

	// slew merge across lanes
	always_comb begin
		logic [15:0] m;
		logic signed [22:0] n;
		slew_on = sum_q > slew_trigger_q;
		for (int i = 0; i < cclim_pkg::NUM_LANES; i++) begin
			m      = (prev_q[i] == 16'sh8000) ? 16'h7fff :
				(prev_q[i][15] ? 16'(-prev_q[i]) : 16'(prev_q[i]));
			p_v[i] = (c_q[i] > 16'sd0) ? signed'(m) : signed'(16'(-m));
		end
		dfl      = 17'(c_q[0]) - 17'(p_v[0]);
		dfl_abs  = dfl[16] ? 17'(-dfl) : 17'(dfl);
		slew_big = dfl_abs > 17'(cclim_pkg::SLEW_BIG);
		slew_mid = dfl_abs > 17'(cclim_pkg::SLEW_MID);
		for (int i = 0; i < cclim_pkg::NUM_LANES; i++) begin
			n = 23'(p_v[i]) * (slew_big ? signed'(23'(cclim_pkg::SLEW_MUL_HI))
				: signed'(23'(cclim_pkg::SLEW_MUL_LO))) + 23'(c_q[i]);
			ext_neg[i] = n[22];
			ext_mag[i] = n[22] ? 22'(-n) : 22'(n);
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			cclim_pkg::S_IDLE: if (in_fire) state_d = cclim_pkg::S_EVAL;
			cclim_pkg::S_EVAL: begin
				if (unl_next) state_d = cclim_pkg::S_DONE;
				else state_d = cclim_pkg::S_MUL;
			end
			cclim_pkg::S_MUL:  state_d = scale_q ? cclim_pkg::S_LOAD : cclim_pkg::S_SLEW;
			cclim_pkg::S_LOAD: state_d = cclim_pkg::S_DIV;
			cclim_pkg::S_DIV:  if (step_q == 4'(cclim_pkg::DIV_STEPS - 1)) state_d = cclim_pkg::S_POST;
			cclim_pkg::S_POST: state_d = phase_q ? cclim_pkg::S_DONE : cclim_pkg::S_SLEW;
			cclim_pkg::S_SLEW: state_d = (slew_on && slew_mid) ? cclim_pkg::S_DIV : cclim_pkg::S_DONE;
			cclim_pkg::S_DONE: if (done_fire) state_d = cclim_pkg::S_IDLE;
			default:           state_d = cclim_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		lane_ctrl = '0;
		case (state_q)
			cclim_pkg::S_LOAD: lane_ctrl.load = 1'b1;
			cclim_pkg::S_SLEW: begin
				lane_ctrl.load    = slew_on && slew_mid;
				lane_ctrl.sel_ext = 1'b1;
			end
			cclim_pkg::S_DIV:  lane_ctrl.step = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cclim_pkg::S_IDLE;
			idle_q    <= '0;
			unl_q     <= 1'b0;
			step_q    <= '0;
			phase_q   <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < cclim_pkg::NUM_LANES; i++) prev_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == cclim_pkg::S_EVAL) begin
				idle_q  <= idle_next;
				unl_q   <= unl_next;
				phase_q <= 1'b0;
			end
			if (state_q == cclim_pkg::S_SLEW) phase_q <= 1'b1;
			step_q <= (state_q == cclim_pkg::S_DIV) ? 4'(step_q + 4'd1) : '0;
			if (done_fire) begin
				out_valid <= 1'b1;
				if (!unl_q)
					for (int i = 0; i < cclim_pkg::NUM_LANES; i++) prev_q[i] <= c_q[i];
			end else if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			c_q[0]      <= front_left;
			c_q[1]      <= front_right;
			c_q[2]      <= back_left;
			c_q[3]      <= back_right;
			power_q     <= power_dw;
			buffer_q    <= energy_buffer;
			releasing_q <= cap_releasing;
			volt_q      <= cap_voltage_mv;
		end
		if (state_q == cclim_pkg::S_EVAL) begin
			sum_q     <= sum;
			divisor_q <= sum;
			if (unl_next) begin
				mode_q  <= cclim_pkg::MODE_UNLIM;
				scale_q <= 1'b0;
				lim_q   <= sum;
			end else if (buf_pct < margin_sum) begin
				mode_q  <= cclim_pkg::MODE_BUFFER;
				scale_q <= sum != '0;
				lim_q   <= (lim_raw > 21'(sum)) ? sum : 18'(lim_raw);
			end else if (!releasing_q || volt_q < cap_min_mv_q) begin
				mode_q  <= cclim_pkg::MODE_CAP;
				scale_q <= sum > current_cap_q;
				lim_q   <= current_cap_q;
			end else begin
				mode_q  <= cclim_pkg::MODE_NONE;
				scale_q <= 1'b0;
				lim_q   <= sum;
			end
		end
		if (state_q == cclim_pkg::S_SLEW)
			divisor_q <= slew_big ? 18'(cclim_pkg::SLEW_DIV_HI) : 18'(cclim_pkg::SLEW_DIV_LO);
		if (state_q == cclim_pkg::S_POST)
			for (int i = 0; i < cclim_pkg::NUM_LANES; i++) c_q[i] <= lane_q[i];
		if (done_fire) begin
			out_front_left  <= c_q[0];
			out_front_right <= c_q[1];
			out_back_left   <= c_q[2];
			out_back_right  <= c_q[3];
			limit_mode      <= mode_q;
		end
	end

	for (genvar g = 0; g < cclim_pkg::NUM_LANES; g++) begin : g_lane
		cclim_lane u_lane (
			.clk     (clk),
			.ctrl    (lane_ctrl),
			.cur     (c_q[g]),
			.lim     (lim_q),
			.ext_mag (ext_mag[g]),
			.ext_neg (ext_neg[g]),
			.divisor (divisor_q),
			.quot    (lane_q[g])
		);
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != cclim_pkg::S_DIV) |=> (step_q == 4'd0))
		else $error("divider step count not cleared");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == cclim_pkg::S_EVAL))
		else $error("accepted word not evaluated");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done_fire && unl_q) |=> $stable(prev_q[0]) && $stable(prev_q[3]))
		else $error("history changed in unlimited mode");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cclim_pkg::S_POST && phase_q) |=> (state_q == cclim_pkg::S_DONE))
		else $error("second divide not followed by result");

endmodule

`default_nettype wire

@@ tb/sv/chassis_current_power_limiter_test.sv @@
// ----------------------------------------------------------------------------
// chassis_current_power_limiter_test
// Drives motor current ticks through the limiter under several register
// settings and idle patterns, predicts each limited word in the bench and
// compares it field by field with the word the block returns.
// ----------------------------------------------------------------------------
`default_nettype none

module chassis_current_power_limiter_test;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic signed [15:0] fl, fr, bl, br;
		logic        [15:0] power;
		logic        [9:0]  buffer;
		logic               releasing;
		logic        [15:0] volt;
	} tick_t;

	typedef struct packed {
		logic signed [15:0] fl, fr, bl, br;
		cclim_pkg::mode_t   mode;
	} limited_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [17:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] front_left = '0, front_right = '0, back_left = '0, back_right = '0;
	logic [15:0] power_dw = '0;
	logic [9:0] energy_buffer = '0;
	logic cap_releasing = 1'b0;
	logic [15:0] cap_voltage_mv = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] out_front_left, out_front_right, out_back_left, out_back_right;
	logic [1:0] limit_mode;

	chassis_current_power_limiter dut (.*);

	// shadow registers and state
	int unsigned margin, base_dw, lim_base, lim_per_buf, cur_cap, cap_min, unlim_ticks, slew_trig;
	int unsigned idle_cnt;
	bit unlim_latched;
	int prev_cur[4];

	limited_t expected_words[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit recv_hold = 1'b0;

	initial forever #6 clk = ~clk;

	initial begin
		#50ms;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int div_tz(longint n, longint d);
		longint q;
		q = (n < 0 ? -n : n) / (d < 0 ? -d : d);
		return int'(((n < 0) != (d < 0)) ? -q : q);
	endfunction

	function automatic int iabs(int v);
		return v < 0 ? -v : v;
	endfunction

	function automatic limited_t limit_tick(tick_t t);
		int c[4];
		int p[4];
		longint sum, excess, lim;
		int dfl, m;
		cclim_pkg::mode_t md;
		limited_t r;
		c[0] = t.fl; c[1] = t.fr; c[2] = t.bl; c[3] = t.br;
		sum = 0;
		for (int i = 0; i < 4; i++) sum += iabs(c[i]);
		if (t.buffer != 0) begin
			idle_cnt = 0;
			unlim_latched = 0;
		end else begin
			if (t.power < 200 && idle_cnt < 255) idle_cnt++;
			if (idle_cnt > unlim_ticks) begin
				idle_cnt = 0;
				unlim_latched = 1;
			end
		end
		if (unlim_latched) begin
			md = cclim_pkg::MODE_UNLIM;
		end else begin
			excess = longint'(t.power) - longint'(base_dw);
			if (excess < 0) excess = 0;
			if (longint'(t.buffer) * 100 - excess < longint'(margin) * 100) begin
				md = cclim_pkg::MODE_BUFFER;
				lim = longint'(lim_base) + longint'(lim_per_buf) * t.buffer;
				if (lim > sum) lim = sum;
				for (int i = 0; i < 4; i++) c[i] = (sum == 0) ? 0 : div_tz(c[i] * lim, sum);
			end else if (!t.releasing || t.volt < cap_min) begin
				md = cclim_pkg::MODE_CAP;
				if (sum > cur_cap)
					for (int i = 0; i < 4; i++) c[i] = div_tz(c[i] * longint'(cur_cap), sum);
			end else begin
				md = cclim_pkg::MODE_NONE;
			end
			if (sum > slew_trig) begin
				for (int i = 0; i < 4; i++) begin
					m = iabs(prev_cur[i]);
					if (m > 32767) m = 32767;
					p[i] = c[i] > 0 ? m : -m;
				end
				dfl = iabs(c[0] - p[0]);
				if (dfl > 2000) begin
					for (int i = 0; i < 4; i++) c[i] = div_tz(longint'(p[i]) * 99 + c[i], 100);
				end else if (dfl > 1000) begin
					for (int i = 0; i < 4; i++) c[i] = div_tz(longint'(p[i]) * 49 + c[i], 50);
				end
			end
			for (int i = 0; i < 4; i++) prev_cur[i] = c[i];
		end
		r.fl = c[0][15:0]; r.fr = c[1][15:0]; r.bl = c[2][15:0]; r.br = c[3][15:0];
		r.mode = md;
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task automatic write_reg(cclim_pkg::reg_idx_t idx, int unsigned val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[17:0];
		@(posedge clk);
		cfg_wen <= 1'b0;
		@(posedge clk);
		case (idx)
			cclim_pkg::REG_BUFFER_MARGIN:    margin = val & 8'hff;
			cclim_pkg::REG_POWER_BASE_DW:    base_dw = val & 12'hfff;
			cclim_pkg::REG_LIMIT_BASE:       lim_base = val & 16'hffff;
			cclim_pkg::REG_LIMIT_PER_BUFFER: lim_per_buf = val & 10'h3ff;
			cclim_pkg::REG_CURRENT_CAP:      cur_cap = val & 18'h3ffff;
			cclim_pkg::REG_CAP_MIN_MV:       cap_min = val & 16'hffff;
			cclim_pkg::REG_UNLIMIT_TICKS:    unlim_ticks = val & 8'hff;
			cclim_pkg::REG_SLEW_TRIGGER:     slew_trig = val & 18'h3ffff;
			default: ;
		endcase
	endtask

	task automatic send_tick(tick_t t);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		{front_left, front_right, back_left, back_right} <= {t.fl, t.fr, t.bl, t.br};
		power_dw <= t.power;
		energy_buffer <= t.buffer;
		cap_releasing <= t.releasing;
		cap_voltage_mv <= t.volt;
		do @(posedge clk); while (!in_ready);
		expected_words.push_back(limit_tick(t));
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (expected_words.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	// receiver side and word checking
	always @(posedge clk) begin
		limited_t w;
		if (out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", 0, 0);
			end else begin
				w = expected_words.pop_front();
				if (out_front_left !== w.fl) report_mismatch("front_left", out_front_left, w.fl);
				if (out_front_right !== w.fr) report_mismatch("front_right", out_front_right, w.fr);
				if (out_back_left !== w.bl) report_mismatch("back_left", out_back_left, w.bl);
				if (out_back_right !== w.br) report_mismatch("back_right", out_back_right, w.br);
				if (limit_mode !== w.mode) report_mismatch("limit_mode", limit_mode, w.mode);
			end
		end
		out_ready <= !recv_hold && !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
	end

	function automatic tick_t rand_tick(int kind);
		tick_t t;
		t = '0;
		t.fl = 16'($urandom); t.fr = 16'($urandom); t.bl = 16'($urandom); t.br = 16'($urandom);
		t.power = 16'($urandom);
		t.buffer = 10'($urandom);
		t.releasing = 1'($urandom);
		t.volt = 16'($urandom);
		case (kind)
			0: begin
				t.power = 16'($urandom_range(2000));
				t.buffer = 10'($urandom_range(60));
			end
			1: begin
				t.buffer = 10'($urandom_range(1023, 40));
				t.power = 16'($urandom_range(800));
				t.releasing = 1'($urandom_range(1));
				t.volt = 16'($urandom_range(20000));
			end
			2: begin
				t.buffer = 0;
				t.power = 16'($urandom_range(199));
			end
			default: begin
				t.buffer = 10'($urandom);
			end
		endcase
		if ($urandom_range(3) == 0) begin
			t.fl = $signed(16'($urandom_range(3000))) - 16'sd1500;
		end
		return t;
	endfunction

	task automatic test_directed();
		tick_t t;
		t = '0; send_tick(t);
		t.fl = 16'sh7fff; t.fr = 16'sh7fff; t.bl = 16'sh7fff; t.br = 16'sh7fff;
		t.buffer = 10'h3ff; t.releasing = 1; t.volt = 16'hffff; send_tick(t);
		t.fl = 16'sh8000; t.fr = 16'sh8000; t.bl = 16'sh8000; t.br = 16'sh8000;
		send_tick(t);
		t.buffer = 5; t.power = 16'hffff; send_tick(t);
		t.fl = 16'sd3000; t.fr = -16'sd3000; t.bl = 16'sd3; t.br = -16'sd7;
		send_tick(t);
		t.buffer = 100; t.power = 0; t.releasing = 0; send_tick(t);
		t.releasing = 1; t.volt = 0; send_tick(t);
		t.volt = 16'hffff; t.fl = 16'sd9000; t.fr = 16'sd4000; send_tick(t);
		t.fl = 16'sd7500; send_tick(t);
		t.fl = 16'sd20000; send_tick(t);
		t = '0; t.fl = 16'sd12; t.fr = -16'sd1;
		for (int i = 0; i < 12; i++) begin
			t.power = 16'(i * 10);
			send_tick(t);
		end
		drain();
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) begin
			int k;
			k = $urandom_range(9);
			send_tick(rand_tick(k < 4 ? 0 : k < 7 ? 1 : k < 9 ? 2 : 3));
		end
		drain();
	endtask

	task automatic test_idle_latch();
		tick_t t;
		for (int i = 0; i < 12; i++) begin
			t = rand_tick(2);
			send_tick(t);
		end
		t = rand_tick(1);
		send_tick(t);
		drain();
	endtask

	task automatic test_backpressure();
		fork
			begin
				recv_hold = 1'b1;
				repeat (400) @(posedge clk);
				recv_hold = 1'b0;
			end
			for (int i = 0; i < 20; i++) send_tick(rand_tick(1));
		join
		drain();
	endtask

	initial begin
		margin = 20; base_dw = 700; lim_base = 2500; lim_per_buf = 192;
		cur_cap = 14500; cap_min = 12000; unlim_ticks = 200; slew_trig = 11000;
		idle_cnt = 0; unlim_latched = 0;
		for (int i = 0; i < 4; i++) prev_cur[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(300);

		write_reg(cclim_pkg::REG_UNLIMIT_TICKS, 3);
		write_reg(cclim_pkg::REG_BUFFER_MARGIN, 255);
		write_reg(cclim_pkg::REG_POWER_BASE_DW, 0);
		test_idle_latch();
		send_idle_pct = 46;
		test_random(300);

		write_reg(cclim_pkg::REG_UNLIMIT_TICKS, 0);
		write_reg(cclim_pkg::REG_BUFFER_MARGIN, 0);
		write_reg(cclim_pkg::REG_POWER_BASE_DW, 4095);
		write_reg(cclim_pkg::REG_LIMIT_BASE, 65535);
		write_reg(cclim_pkg::REG_LIMIT_PER_BUFFER, 1023);
		write_reg(cclim_pkg::REG_CURRENT_CAP, 0);
		write_reg(cclim_pkg::REG_CAP_MIN_MV, 65535);
		write_reg(cclim_pkg::REG_SLEW_TRIGGER, 0);
		send_idle_pct = 0; recv_stall_pct = 46;
		test_random(300);

		write_reg(cclim_pkg::REG_UNLIMIT_TICKS, 254);
		write_reg(cclim_pkg::REG_LIMIT_BASE, 0);
		write_reg(cclim_pkg::REG_LIMIT_PER_BUFFER, 0);
		write_reg(cclim_pkg::REG_CURRENT_CAP, 131072);
		write_reg(cclim_pkg::REG_CAP_MIN_MV, 0);
		write_reg(cclim_pkg::REG_SLEW_TRIGGER, 131072);
		write_reg(cclim_pkg::REG_BUFFER_MARGIN, 40);
		send_idle_pct = 16; recv_stall_pct = 16;
		test_random(300);
		test_backpressure();

		write_reg(cclim_pkg::REG_UNLIMIT_TICKS, 255);
		write_reg(cclim_pkg::REG_BUFFER_MARGIN, 20);
		write_reg(cclim_pkg::REG_POWER_BASE_DW, 700);
		write_reg(cclim_pkg::REG_LIMIT_BASE, 2500);
		write_reg(cclim_pkg::REG_LIMIT_PER_BUFFER, 192);
		write_reg(cclim_pkg::REG_CURRENT_CAP, 14500);
		write_reg(cclim_pkg::REG_CAP_MIN_MV, 12000);
		write_reg(cclim_pkg::REG_SLEW_TRIGGER, 5000);
		send_idle_pct = 0; recv_stall_pct = 0;
		test_idle_latch();
		test_random(450);

		if (errors == 0 && expected_words.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

@@ files.f @@
hw/rtl/cclim_pkg.sv
hw/rtl/cclim_lane.sv
hw/rtl/chassis_current_power_limiter.sv
tb/sv/chassis_current_power_limiter_test.sv
